[src/fdfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdfa_pkg
// Shared widths, codes, micro-op table and controller/datapath link types of
// the facet drag force accumulator.
// ----------------------------------------------------------------------------
package fdfa_pkg;

  // Arithmetic word: signed fixed point, FRAC_BITS fraction bits.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Field widths of the stream items and registers.
  localparam int NORM_BITS  = 18;
  localparam int POS_BITS   = 32;
  localparam int AREA_BITS  = 31;
  localparam int CFG_BITS   = 31;
  localparam int OUT_BITS   = 32;

  localparam int IN_FIELD_BITS  = 3 * NORM_BITS + 6 * POS_BITS + AREA_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 6 * OUT_BITS;

  // Input field offsets inside tdata, lowest field first.
  localparam int OFS_NX   = 0;
  localparam int OFS_NY   = OFS_NX + NORM_BITS;
  localparam int OFS_NZ   = OFS_NY + NORM_BITS;
  localparam int OFS_CX   = OFS_NZ + NORM_BITS;
  localparam int OFS_CY   = OFS_CX + POS_BITS;
  localparam int OFS_CZ   = OFS_CY + POS_BITS;
  localparam int OFS_AREA = OFS_CZ + POS_BITS;
  localparam int OFS_VX   = OFS_AREA + AREA_BITS;
  localparam int OFS_VY   = OFS_VX + POS_BITS;
  localparam int OFS_VZ   = OFS_VY + POS_BITS;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VISC_FORWARD   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VISC_BACKWARD  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VISC_LATERAL   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STILL_SPEED_SQ = 2'd3;

  localparam logic [CFG_BITS-1:0] RST_VISC_FORWARD   = CFG_BITS'(13107);
  localparam logic [CFG_BITS-1:0] RST_VISC_BACKWARD  = CFG_BITS'(6554);
  localparam logic [CFG_BITS-1:0] RST_VISC_LATERAL   = CFG_BITS'(3277);
  localparam logic [CFG_BITS-1:0] RST_STILL_SPEED_SQ = CFG_BITS'(0);

  // Micro-op operations.
  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_SKIP,
    OP_COMMIT
  } op_e;

  // Operand sources and destinations.
  typedef enum logic [4:0] {
    SRC_N0, SRC_N1, SRC_N2,
    SRC_C0, SRC_C1, SRC_C2,
    SRC_V0, SRC_V1, SRC_V2,
    SRC_AREA, SRC_KN, SRC_KL, SRC_STILL, SRC_ZERO,
    SRC_TA, SRC_TB, SRC_DOT, SRC_VN, SRC_VT,
    SRC_F0, SRC_F1, SRC_F2,
    SRC_FS0, SRC_FS1, SRC_FS2,
    SRC_MS0, SRC_MS1, SRC_MS2
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
    logic flag;   // clamps of this op feed the saturation flag
  } uop_t;

  localparam int STEP_BITS = 6;
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(47);

  typedef struct packed {
    uop_t uop;
    logic exec;      // issue the current micro-op
    logic mul_wb;    // write back the registered product
    logic load_in;   // capture an input transaction
    logic load_out;  // move the sums to the result register and clear them
  } cmd_t;

  typedef struct packed {
    logic still;     // squared speed at or below threshold
    logic last;      // captured facet closes the mesh
  } stat_t;

  function automatic uop_t mk(op_e op, src_e a, src_e b, src_e dst, logic flag);
    uop_t u;
    u.op   = op;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    u.flag = flag;
    return u;
  endfunction

  // Per-facet micro-op sequence.
  function automatic uop_t uop_f(logic [STEP_BITS-1:0] step);
    uop_t u;
    u = mk(OP_COMMIT, SRC_ZERO, SRC_ZERO, SRC_TA, 1'b0);
    case (step)
      // squared speed, never flagged
      6'd0:  u = mk(OP_MUL,  SRC_V0,  SRC_V0,    SRC_TA,  1'b0);
      6'd1:  u = mk(OP_MUL,  SRC_V1,  SRC_V1,    SRC_TB,  1'b0);
      6'd2:  u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_TA,  1'b0);
      6'd3:  u = mk(OP_MUL,  SRC_V2,  SRC_V2,    SRC_TB,  1'b0);
      6'd4:  u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_TA,  1'b0);
      6'd5:  u = mk(OP_SKIP, SRC_TA,  SRC_STILL, SRC_TA,  1'b0);
      // v.n
      6'd6:  u = mk(OP_MUL,  SRC_V0,  SRC_N0,    SRC_TA,  1'b1);
      6'd7:  u = mk(OP_MUL,  SRC_V1,  SRC_N1,    SRC_TB,  1'b1);
      6'd8:  u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd9:  u = mk(OP_MUL,  SRC_V2,  SRC_N2,    SRC_TB,  1'b1);
      6'd10: u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_DOT, 1'b1);
      // x force
      6'd11: u = mk(OP_MUL,  SRC_N0,  SRC_DOT,   SRC_VN,  1'b1);
      6'd12: u = mk(OP_SUB,  SRC_V0,  SRC_VN,    SRC_VT,  1'b1);
      6'd13: u = mk(OP_MUL,  SRC_VN,  SRC_KN,    SRC_TA,  1'b1);
      6'd14: u = mk(OP_MUL,  SRC_VT,  SRC_KL,    SRC_TB,  1'b1);
      6'd15: u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd16: u = mk(OP_MUL,  SRC_TA,  SRC_AREA,  SRC_TA,  1'b1);
      6'd17: u = mk(OP_SUB,  SRC_ZERO, SRC_TA,   SRC_F0,  1'b1);
      // y force
      6'd18: u = mk(OP_MUL,  SRC_N1,  SRC_DOT,   SRC_VN,  1'b1);
      6'd19: u = mk(OP_SUB,  SRC_V1,  SRC_VN,    SRC_VT,  1'b1);
      6'd20: u = mk(OP_MUL,  SRC_VN,  SRC_KN,    SRC_TA,  1'b1);
      6'd21: u = mk(OP_MUL,  SRC_VT,  SRC_KL,    SRC_TB,  1'b1);
      6'd22: u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd23: u = mk(OP_MUL,  SRC_TA,  SRC_AREA,  SRC_TA,  1'b1);
      6'd24: u = mk(OP_SUB,  SRC_ZERO, SRC_TA,   SRC_F1,  1'b1);
      // z force
      6'd25: u = mk(OP_MUL,  SRC_N2,  SRC_DOT,   SRC_VN,  1'b1);
      6'd26: u = mk(OP_SUB,  SRC_V2,  SRC_VN,    SRC_VT,  1'b1);
      6'd27: u = mk(OP_MUL,  SRC_VN,  SRC_KN,    SRC_TA,  1'b1);
      6'd28: u = mk(OP_MUL,  SRC_VT,  SRC_KL,    SRC_TB,  1'b1);
      6'd29: u = mk(OP_ADD,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd30: u = mk(OP_MUL,  SRC_TA,  SRC_AREA,  SRC_TA,  1'b1);
      6'd31: u = mk(OP_SUB,  SRC_ZERO, SRC_TA,   SRC_F2,  1'b1);
      // moments, accumulated as they complete
      6'd32: u = mk(OP_MUL,  SRC_C1,  SRC_F2,    SRC_TA,  1'b1);
      6'd33: u = mk(OP_MUL,  SRC_C2,  SRC_F1,    SRC_TB,  1'b1);
      6'd34: u = mk(OP_SUB,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd35: u = mk(OP_ADD,  SRC_MS0, SRC_TA,    SRC_MS0, 1'b1);
      6'd36: u = mk(OP_MUL,  SRC_C2,  SRC_F0,    SRC_TA,  1'b1);
      6'd37: u = mk(OP_MUL,  SRC_C0,  SRC_F2,    SRC_TB,  1'b1);
      6'd38: u = mk(OP_SUB,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd39: u = mk(OP_ADD,  SRC_MS1, SRC_TA,    SRC_MS1, 1'b1);
      6'd40: u = mk(OP_MUL,  SRC_C0,  SRC_F1,    SRC_TA,  1'b1);
      6'd41: u = mk(OP_MUL,  SRC_C1,  SRC_F0,    SRC_TB,  1'b1);
      6'd42: u = mk(OP_SUB,  SRC_TA,  SRC_TB,    SRC_TA,  1'b1);
      6'd43: u = mk(OP_ADD,  SRC_MS2, SRC_TA,    SRC_MS2, 1'b1);
      // force sums
      6'd44: u = mk(OP_ADD,  SRC_FS0, SRC_F0,    SRC_FS0, 1'b1);
      6'd45: u = mk(OP_ADD,  SRC_FS1, SRC_F1,    SRC_FS1, 1'b1);
      6'd46: u = mk(OP_ADD,  SRC_FS2, SRC_F2,    SRC_FS2, 1'b1);
      6'd47: u = mk(OP_COMMIT, SRC_ZERO, SRC_ZERO, SRC_TA,  1'b0);
      default: u = mk(OP_COMMIT, SRC_ZERO, SRC_ZERO, SRC_TA, 1'b0);
    endcase
    return u;
  endfunction

endpackage

[src/facet_drag_force_accumulator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facet_drag_force_accumulator_unit
// Sums viscous drag force and moment about the origin over a stream of mesh
// facets; emits and clears the sums on the facet that closes the mesh.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Handshake
//  s_axis    in         one facet (tdata) + last facet (tlast)   tvalid/tready
//  m_axis    out        summed force/moment (tdata) + sat flag   tvalid/tready
//  cfg       in         register index + 31-bit value            write enable
//
//  A facet passes from acceptance to the next ready through one accept
//  state, 48 micro-ops with a writeback state after each of the 24 multiplies
//  on the single shared multiplier, and one finish state. A facet at or
//  below the squared-speed threshold ends its sequence at the skip micro-op.
//  Reset (asynchronous, active low) clears the sums, the flag, the
//  sequencer and restores the register defaults.
//  The result register lets the next facet be taken while a result waits;
//  a closing facet holds in its finish cycle until the pending result goes.
//
module facet_drag_force_accumulator_unit
  import fdfa_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // fields from bit 0 up: normal_x, normal_y, normal_z, centroid_x,
  // centroid_y, centroid_z, facet_area, speed_x, speed_y, speed_z, zero pad
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  input  logic                      s_axis_tlast,    // last_facet
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // fields from bit 0 up: force_x, force_y, force_z, moment_x, moment_y,
  // moment_z
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  output logic                      m_axis_tuser,    // saturated
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_BITS-1:0]       cfg_data_i
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: accept a transaction, walk the micro-op table, hand off result
  fdfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: hold the facet, multiply and clamp, accumulate, drive results
  fdfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

[src/fdfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdfa_ctrl
// Sequencer: steps through the micro-op table once per facet and hands the
// result to the output register when a facet closes the mesh.
// ----------------------------------------------------------------------------
module fdfa_ctrl
  import fdfa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_tvalid_i,
  output logic  s_tready_o,
  output logic  m_tvalid_o,
  input  logic  m_tready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MWB  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cmd_o     = '0;
    cmd_o.uop = uop_f(step_q);
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = '0;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (cmd_o.uop.op == OP_MUL) begin
          state_d = S_MWB;
        end else if ((cmd_o.uop.op == OP_SKIP && stat_i.still) || step_q == STEP_LAST) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + STEP_BITS'(1);
        end
      end
      S_MWB: begin
        cmd_o.mul_wb = 1'b1;
        step_d       = step_q + STEP_BITS'(1);
        state_d      = S_EXEC;
      end
      S_FIN: begin
        if (!stat_i.last) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  a_mwb_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MWB |-> $past(state_q) == S_EXEC && $past(cmd_o.uop.op) == OP_MUL)
    else $error("product writeback without a multiply issue");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> step_q <= STEP_LAST)
    else $error("micro-op step beyond the table");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten while still pending");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> state_q == S_EXEC && step_q == '0)
    else $error("accepted facet did not start the sequence");

endmodule

[src/fdfa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdfa_datapath
// Operand registers, shared multiplier with clamp, saturating adder,
// running sums, configuration registers and result register.
// ----------------------------------------------------------------------------
module fdfa_datapath
  import fdfa_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata_i,
  input  logic                      s_tlast_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_BITS-1:0]       cfg_data_i,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  output logic [OUT_TDATA_BITS-1:0] m_tdata_o,
  output logic                      m_tuser_o
);

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] LIM_POS = (2*W)'(SMAX);
  localparam logic [2*W-1:0] LIM_NEG = LIM_POS + (2*W)'(1);

  // configuration
  logic [CFG_BITS-1:0] kf_q, kb_q, kl_q, still_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kf_q    <= RST_VISC_FORWARD;
      kb_q    <= RST_VISC_BACKWARD;
      kl_q    <= RST_VISC_LATERAL;
      still_q <= RST_STILL_SPEED_SQ;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VISC_FORWARD:   kf_q    <= cfg_data_i;
        CFG_VISC_BACKWARD:  kb_q    <= cfg_data_i;
        CFG_VISC_LATERAL:   kl_q    <= cfg_data_i;
        CFG_STILL_SPEED_SQ: still_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured facet
  logic [NORM_BITS-1:0] n_q [3];
  logic [POS_BITS-1:0]  c_q [3];
  logic [POS_BITS-1:0]  v_q [3];
  logic [AREA_BITS-1:0] area_q;
  logic                 last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      n_q[0] <= s_tdata_i[OFS_NX +: NORM_BITS];
      n_q[1] <= s_tdata_i[OFS_NY +: NORM_BITS];
      n_q[2] <= s_tdata_i[OFS_NZ +: NORM_BITS];
      c_q[0] <= s_tdata_i[OFS_CX +: POS_BITS];
      c_q[1] <= s_tdata_i[OFS_CY +: POS_BITS];
      c_q[2] <= s_tdata_i[OFS_CZ +: POS_BITS];
      area_q <= s_tdata_i[OFS_AREA +: AREA_BITS];
      v_q[0] <= s_tdata_i[OFS_VX +: POS_BITS];
      v_q[1] <= s_tdata_i[OFS_VY +: POS_BITS];
      v_q[2] <= s_tdata_i[OFS_VZ +: POS_BITS];
      last_q <= s_tlast_i;
    end
  end

  // scratch and sums
  logic [W-1:0] ta_q, tb_q, dot_q, vn_q, vt_q;
  logic [W-1:0] f_q  [3];
  logic [W-1:0] fs_q [3];
  logic [W-1:0] ms_q [3];

  function automatic logic [W-1:0] pick(src_e s, logic [W-1:0] kn);
    logic [W-1:0] r;
    r = '0;
    case (s)
      SRC_N0:    r = W'($signed(n_q[0]));
      SRC_N1:    r = W'($signed(n_q[1]));
      SRC_N2:    r = W'($signed(n_q[2]));
      SRC_C0:    r = W'($signed(c_q[0]));
      SRC_C1:    r = W'($signed(c_q[1]));
      SRC_C2:    r = W'($signed(c_q[2]));
      SRC_V0:    r = W'($signed(v_q[0]));
      SRC_V1:    r = W'($signed(v_q[1]));
      SRC_V2:    r = W'($signed(v_q[2]));
      SRC_AREA:  r = W'(area_q);
      SRC_KN:    r = kn;
      SRC_KL:    r = W'(kl_q);
      SRC_STILL: r = W'(still_q);
      SRC_ZERO:  r = '0;
      SRC_TA:    r = ta_q;
      SRC_TB:    r = tb_q;
      SRC_DOT:   r = dot_q;
      SRC_VN:    r = vn_q;
      SRC_VT:    r = vt_q;
      SRC_F0:    r = f_q[0];
      SRC_F1:    r = f_q[1];
      SRC_F2:    r = f_q[2];
      SRC_FS0:   r = fs_q[0];
      SRC_FS1:   r = fs_q[1];
      SRC_FS2:   r = fs_q[2];
      SRC_MS0:   r = ms_q[0];
      SRC_MS1:   r = ms_q[1];
      SRC_MS2:   r = ms_q[2];
      default:   r = '0;
    endcase
    return r;
  endfunction

  logic [W-1:0] kn, opa, opb;

  // forward coefficient when v.n is non-negative
  assign kn = dot_q[W-1] ? W'(kb_q) : W'(kf_q);

  // re-evaluate on any register the selected source reads
  always_comb begin
    opa = pick(cmd_i.uop.a, kn);
    opb = pick(cmd_i.uop.b, kn);
  end

  // multiplier: sign-magnitude product, registered, then shift and clamp
  logic [W-1:0]   mag_a, mag_b;
  logic [2*W-1:0] prod_d, prod_q, prod_sh;
  logic           neg_q, mul_sat;
  logic [W-1:0]   mul_res;

  assign mag_a  = opa[W-1] ? -opa : opa;
  assign mag_b  = opb[W-1] ? -opb : opb;
  assign prod_d = mag_a * mag_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && cmd_i.uop.op == OP_MUL) begin
      prod_q <= prod_d;
      neg_q  <= opa[W-1] ^ opb[W-1];
    end
  end

  assign prod_sh = prod_q >> FRAC_BITS;
  assign mul_sat = prod_sh > (neg_q ? LIM_NEG : LIM_POS);
  assign mul_res = mul_sat ? (neg_q ? SMIN : SMAX)
                           : (neg_q ? -prod_sh[W-1:0] : prod_sh[W-1:0]);

  // saturating add / subtract
  logic [W:0]   alu_sum;
  logic         alu_sat;
  logic [W-1:0] alu_res;

  assign alu_sum = (cmd_i.uop.op == OP_SUB) ? {opa[W-1], opa} - {opb[W-1], opb}
                                            : {opa[W-1], opa} + {opb[W-1], opb};
  assign alu_sat = alu_sum[W] ^ alu_sum[W-1];
  assign alu_res = alu_sat ? (alu_sum[W] ? SMIN : SMAX) : alu_sum[W-1:0];

  // writeback
  logic         wr_en, wr_sat;
  logic [W-1:0] wr_val;

  assign wr_en  = cmd_i.mul_wb ||
                  (cmd_i.exec && (cmd_i.uop.op == OP_ADD || cmd_i.uop.op == OP_SUB));
  assign wr_val = cmd_i.mul_wb ? mul_res : alu_res;
  assign wr_sat = cmd_i.mul_wb ? mul_sat : alu_sat;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (cmd_i.uop.dst)
        SRC_TA:  ta_q   <= wr_val;
        SRC_TB:  tb_q   <= wr_val;
        SRC_DOT: dot_q  <= wr_val;
        SRC_VN:  vn_q   <= wr_val;
        SRC_VT:  vt_q   <= wr_val;
        SRC_F0:  f_q[0] <= wr_val;
        SRC_F1:  f_q[1] <= wr_val;
        SRC_F2:  f_q[2] <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q[0] <= '0;
      fs_q[1] <= '0;
      fs_q[2] <= '0;
      ms_q[0] <= '0;
      ms_q[1] <= '0;
      ms_q[2] <= '0;
    end else if (cmd_i.load_out) begin
      fs_q[0] <= '0;
      fs_q[1] <= '0;
      fs_q[2] <= '0;
      ms_q[0] <= '0;
      ms_q[1] <= '0;
      ms_q[2] <= '0;
    end else if (wr_en) begin
      case (cmd_i.uop.dst)
        SRC_FS0: fs_q[0] <= wr_val;
        SRC_FS1: fs_q[1] <= wr_val;
        SRC_FS2: fs_q[2] <= wr_val;
        SRC_MS0: ms_q[0] <= wr_val;
        SRC_MS1: ms_q[1] <= wr_val;
        SRC_MS2: ms_q[2] <= wr_val;
        default: ;
      endcase
    end
  end

  // saturation: per facet, folded into the run flag on commit
  logic sat_item_q, sat_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_item_q <= 1'b0;
      sat_seen_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        sat_item_q <= 1'b0;
      end else if (wr_en && cmd_i.uop.flag && wr_sat) begin
        sat_item_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        sat_seen_q <= 1'b0;
      end else if (cmd_i.exec && cmd_i.uop.op == OP_COMMIT && sat_item_q) begin
        sat_seen_q <= 1'b1;
      end
    end
  end

  // result register
  logic [W-1:0] fo_q [3];
  logic [W-1:0] mo_q [3];
  logic         sat_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      fo_q[0]   <= fs_q[0];
      fo_q[1]   <= fs_q[1];
      fo_q[2]   <= fs_q[2];
      mo_q[0]   <= ms_q[0];
      mo_q[1]   <= ms_q[1];
      mo_q[2]   <= ms_q[2];
      sat_out_q <= sat_seen_q;
    end
  end

  assign m_tdata_o = {OUT_BITS'(mo_q[2]), OUT_BITS'(mo_q[1]), OUT_BITS'(mo_q[0]),
                      OUT_BITS'(fo_q[2]), OUT_BITS'(fo_q[1]), OUT_BITS'(fo_q[0])};
  assign m_tuser_o = sat_out_q;

  assign stat_o.still = !($signed(ta_q) > $signed(W'(still_q)));
  assign stat_o.last  = last_q;

endmodule
